/* rtl/core/fpalu_pkg.sv */
// Package for the fixed-point ALU: operation codes and result flag type.
// No dependencies.
package fpalu_pkg;
	localparam int KIND_W = 4;
	localparam logic [KIND_W-1:0] OP_ADD = 4'd0;
	localparam logic [KIND_W-1:0] OP_SUB = 4'd1;
	localparam logic [KIND_W-1:0] OP_MUL = 4'd2;
	localparam logic [KIND_W-1:0] OP_DIV = 4'd3;
	localparam logic [KIND_W-1:0] OP_MIN = 4'd4;
	localparam logic [KIND_W-1:0] OP_MAX = 4'd5;
	localparam logic [KIND_W-1:0] OP_INC = 4'd6;
	localparam logic [KIND_W-1:0] OP_DEC = 4'd7;
	localparam logic [KIND_W-1:0] OP_RND = 4'd8;
	localparam logic [KIND_W-1:0] OP_I2F = 4'd9;
	localparam int IO_W = 32;

	typedef struct packed {
		logic a_less;
		logic a_equal;
	} cmp_flags_t;
endpackage

/* rtl/core/fpalu_if.sv */
// Valid/ready channel interfaces for the fixed-point ALU.
// Depends on fpalu_pkg.
interface fpalu_in_if;
	logic                              valid;
	logic                              ready;
	logic [fpalu_pkg::KIND_W-1:0]      kind;
	logic signed [fpalu_pkg::IO_W-1:0] operand_a;
	logic signed [fpalu_pkg::IO_W-1:0] operand_b;
	modport source (output valid, kind, operand_a, operand_b, input ready);
	modport sink (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface fpalu_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [fpalu_pkg::IO_W-1:0] result_value;
	logic                              a_less;
	logic                              a_equal;
	logic                              overflowed;
	logic                              divide_by_zero;
	modport source (output valid, result_value, a_less, a_equal, overflowed,
		divide_by_zero, input ready);
	modport sink (input valid, result_value, a_less, a_equal, overflowed,
		divide_by_zero, output ready);
endinterface

/* rtl/core/fixed_point_alu.sv */
// Fixed-point ALU top level: pipeline, multiplier and divider hookup.
// Stages: stage 1, OPW + FRAC_BITS + 2 divider stages and one output stage.
// Throughput: one beat per cycle while the output is not stalled; every op travels
// the same depth, set by the divider chain.
// A stall at the output freezes the whole pipeline; one skid-free enable covers all stages.
// Reset clears the valid bits only; payload registers are not reset.
// Depends on fpalu_pkg, fpalu_if and fpalu_div.
module fixed_point_alu #(
	parameter int FRAC_BITS  = 8,
	parameter int WORD_WIDTH = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	fpalu_in_if.sink    in_ch,
	fpalu_out_if.source out_ch
);
	localparam int OPW = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
	localparam int XW  = (2 * OPW + 2 > OPW + FRAC_BITS + 2) ? 2 * OPW + 2
		: OPW + FRAC_BITS + 2;
	localparam int NW  = OPW + FRAC_BITS + 1;
	localparam int KW  = fpalu_pkg::KIND_W;
	localparam int DEPTH = NW + 1;

	// saturation bounds in SW bits, the wider of WORD_WIDTH and XW
	localparam int SW = (WORD_WIDTH > XW) ? WORD_WIDTH : XW;

	logic en;
	assign en = out_ch.ready || !out_ch.valid;
	assign in_ch.ready = en;

	// stage 1: operands, product, simple ops
	logic signed [OPW-1:0] a_w, b_w;
	assign a_w = in_ch.operand_a[OPW-1:0];
	assign b_w = in_ch.operand_b[OPW-1:0];

	logic        v_s1;
	logic [KW-1:0] k_s1;
	logic signed [XW-1:0] prod_s1, simp_s1;
	logic neg_s1, dbz_s1;
	fpalu_pkg::cmp_flags_t cmp_s1;
	logic [OPW:0] ma_s1, mb_s1;

	logic signed [XW-1:0] ax, bx, simp_c;
	logic signed [2*OPW-1:0] prod_c;
	assign ax = XW'(a_w);
	assign bx = XW'(b_w);
	assign prod_c = a_w * b_w;
	always_comb begin
		case (in_ch.kind)
			fpalu_pkg::OP_ADD: simp_c = ax + bx;
			fpalu_pkg::OP_SUB: simp_c = ax - bx;
			fpalu_pkg::OP_MIN: simp_c = (ax > bx) ? bx : ax;
			fpalu_pkg::OP_MAX: simp_c = (ax > bx) ? ax : bx;
			fpalu_pkg::OP_INC: simp_c = ax + XW'(1);
			fpalu_pkg::OP_DEC: simp_c = ax - XW'(1);
			fpalu_pkg::OP_I2F: simp_c = bx <<< FRAC_BITS;
			default:           simp_c = ax;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			k_s1    <= in_ch.kind;
			prod_s1 <= XW'(prod_c);
			simp_s1 <= simp_c;
			neg_s1  <= a_w[OPW-1] ^ b_w[OPW-1];
			dbz_s1  <= (b_w == '0);
			cmp_s1  <= '{a_less: (a_w < b_w), a_equal: (a_w == b_w)};
			ma_s1   <= a_w[OPW-1] ? (OPW+1)'(-ax) : (OPW+1)'(ax);
			mb_s1   <= b_w[OPW-1] ? (OPW+1)'(-bx) : (OPW+1)'(bx);
		end
	end

	// stage 2: round magnitude for mul/round; operands for divider
	logic [XW-1:0] mag_c;
	logic          sgn_c;
	assign sgn_c = (k_s1 == fpalu_pkg::OP_MUL) ? prod_s1[XW-1] : simp_s1[XW-1];
	assign mag_c = (k_s1 == fpalu_pkg::OP_MUL)
		? (prod_s1[XW-1] ? XW'(-prod_s1) : XW'(prod_s1))
		: (simp_s1[XW-1] ? XW'(-simp_s1) : XW'(simp_s1));

	logic signed [XW-1:0] rnd_c;
	logic [XW-1:0] rm_c;
	assign rm_c  = (mag_c + (XW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
	assign rnd_c = sgn_c ? XW'(-rm_c) : XW'(rm_c);

	// numerator 2*|a|<<F + |b|, denominator 2*|b|
	logic [NW:0] num_c;
	assign num_c = ((NW+1)'(ma_s1) << (FRAC_BITS + 1)) + (NW+1)'(mb_s1);

	typedef struct packed {
		logic [KW-1:0] k;
		logic signed [XW-1:0] r;
		logic          neg;
		logic          dbz;
		fpalu_pkg::cmp_flags_t cmp;
	} tag_t;
	localparam int TW = $bits(tag_t);

	tag_t tag_c, tag_o;
	assign tag_c = '{k: k_s1,
		r: ((k_s1 == fpalu_pkg::OP_MUL) || (k_s1 == fpalu_pkg::OP_RND)) ? rnd_c : simp_s1,
		neg: neg_s1, dbz: dbz_s1, cmp: cmp_s1};

	logic [NW:0] quo;
	logic [TW-1:0] tag_raw;
	fpalu_div #(.NW(NW + 1), .DW(OPW + 2), .TW(TW)) u_div (
		.clk(clk), .en(en), .num(num_c), .den({mb_s1, 1'b0}),
		.tag(tag_c), .quo(quo), .tag_out(tag_raw)
	);
	assign tag_o = tag_t'(tag_raw);

	// valid chain shadows the divider
	logic [DEPTH-1:0] vchain_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vchain_q <= '0;
		end else if (en) begin
			vchain_q <= {vchain_q[DEPTH-2:0], v_s1};
		end
	end

	// final stage: select, saturate; zero results for divide by zero and unknown ops
	logic signed [SW-1:0] maxv, minv, pick;
	assign maxv = SW'((65'sd1 <<< (WORD_WIDTH - 1)) - 65'sd1);
	assign minv = -maxv - SW'(1);
	logic [NW+1:0] qx;
	assign qx = {1'b0, quo};
	always_comb begin
		case (tag_o.k)
			fpalu_pkg::OP_DIV:
				pick = tag_o.neg ? -SW'(qx) : SW'(qx);
			default: pick = SW'(tag_o.r);
		endcase
	end

	logic sat_ok;
	assign sat_ok = (tag_o.k == fpalu_pkg::OP_ADD) || (tag_o.k == fpalu_pkg::OP_SUB)
		|| (tag_o.k == fpalu_pkg::OP_MUL) || (tag_o.k == fpalu_pkg::OP_DIV)
		|| (tag_o.k == fpalu_pkg::OP_INC) || (tag_o.k == fpalu_pkg::OP_DEC)
		|| (tag_o.k == fpalu_pkg::OP_I2F);

	logic over_c;
	logic signed [SW-1:0] res_c;
	always_comb begin
		over_c = 1'b0;
		res_c  = pick;
		if (tag_o.k == fpalu_pkg::OP_DIV && tag_o.dbz) begin
			res_c = '0;
		end else if (sat_ok && pick > maxv) begin
			res_c = maxv; over_c = 1'b1;
		end else if (sat_ok && pick < minv) begin
			res_c = minv; over_c = 1'b1;
		end
		if (tag_o.k > fpalu_pkg::OP_I2F) begin
			res_c = '0;
		end
	end

	logic vo_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (en) begin
			vo_q <= vchain_q[DEPTH-1];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.result_value   <= res_c[fpalu_pkg::IO_W-1:0];
			out_ch.a_less         <= tag_o.cmp.a_less;
			out_ch.a_equal        <= tag_o.cmp.a_equal;
			out_ch.overflowed     <= over_c;
			out_ch.divide_by_zero <= (tag_o.k == fpalu_pkg::OP_DIV) && tag_o.dbz;
		end
	end
	assign out_ch.valid = vo_q;

	// a stalled output holds its beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result_value))
		else $error("output beat changed under stall");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.overflowed && out_ch.divide_by_zero))
		else $error("overflow and divide by zero together");
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.a_less && out_ch.a_equal))
		else $error("less and equal together");
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> v_s1)
		else $error("accepted beat lost at stage 1");
endmodule

/* rtl/core/fpalu_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with stall enable.
// Depends on nothing but its parameters.
module fpalu_div #(
	parameter int NW = 64,
	parameter int DW = 33,
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag,
	output logic [NW-1:0] quo,
	output logic [TW-1:0] tag_out
);
	logic [NW-1:0] q_s   [1:NW];
	logic [DW:0]   rem_s [1:NW];
	logic [DW-1:0] d_s   [1:NW];
	logic [TW-1:0] t_s   [1:NW];

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [NW-1:0] qi;
		logic [DW:0]   ri;
		logic [DW-1:0] di;
		logic [TW-1:0] ti;
		logic [DW:0] sh;
		logic [DW:0] df;
		logic        ge;
		if (i == 0) begin : g_head
			assign qi = num;
			assign ri = '0;
			assign di = den;
			assign ti = tag;
		end else begin : g_body
			assign qi = q_s[i];
			assign ri = rem_s[i];
			assign di = d_s[i];
			assign ti = t_s[i];
		end
		assign sh = {ri[DW-1:0], qi[NW-1]};
		assign ge = sh >= {1'b0, di};
		assign df = sh - {1'b0, di};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? df : sh;
				q_s[i+1]   <= {qi[NW-2:0], ge};
				d_s[i+1]   <= di;
				t_s[i+1]   <= ti;
			end
		end
	end

	assign quo     = q_s[NW];
	assign tag_out = t_s[NW];
endmodule

/* tb/fpalu_tb_if.sv */
`timescale 1ns / 1ps
// Testbench copy point for channel interfaces: none needed beyond the RTL ones.
// Depends on fpalu_pkg from the RTL.
package fpalu_tb_pkg;
	typedef struct {
		logic signed [fpalu_pkg::IO_W-1:0] value;
		logic                              less;
		logic                              equal;
		logic                              ovf;
		logic                              dbz;
	} alu_result_t;
endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top-level testbench for fixed_point_alu: directed table, then random beats, each checked
// in order against a typed-in value or an exact Q24.8 predictor. Depends on fpalu_pkg, fpalu_if.
module tb_top;
	localparam int FRAC = 8;
	localparam int WORD = 32;
	localparam int QUIET_LIMIT = 4000;
	localparam int N_RANDOM = 600;
	localparam int KIND_W = fpalu_pkg::KIND_W;
	localparam int IO_W = fpalu_pkg::IO_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	fpalu_in_if  in_ch ();
	fpalu_out_if out_ch ();

	fixed_point_alu #(.FRAC_BITS(FRAC), .WORD_WIDTH(WORD)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	fpalu_tb_pkg::alu_result_t pending_results[$];
	int errors = 0;
	int quiet = 0;
	bit calm = 1'b0;
	bit stim_done = 1'b0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic longint sat32(longint v, ref logic ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint round_shift(longint v);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
		return (v < 0) ? -m : m;
	endfunction

	function automatic fpalu_tb_pkg::alu_result_t alu_predict(logic [KIND_W-1:0] k,
			logic signed [IO_W-1:0] a32, logic signed [IO_W-1:0] b32);
		fpalu_tb_pkg::alu_result_t res;
		longint a, b, r;
		longint unsigned num, den, q;
		logic ovf, dbz;
		a = a32;
		b = b32;
		r = 0;
		ovf = 1'b0;
		dbz = 1'b0;
		case (k)
			fpalu_pkg::OP_ADD: r = sat32(a + b, ovf);
			fpalu_pkg::OP_SUB: r = sat32(a - b, ovf);
			fpalu_pkg::OP_MUL: r = sat32(round_shift(a * b), ovf);
			fpalu_pkg::OP_DIV: begin
				if (b == 0) begin
					dbz = 1'b1;
				end else begin
					num = ((a < 0) ? -a : a) << FRAC;
					den = (b < 0) ? -b : b;
					q = (2 * num + den) / (2 * den);
					r = ((a < 0) != (b < 0)) ? -longint'(q) : longint'(q);
					r = sat32(r, ovf);
				end
			end
			fpalu_pkg::OP_MIN: r = (a > b) ? b : a;
			fpalu_pkg::OP_MAX: r = (a > b) ? a : b;
			fpalu_pkg::OP_INC: r = sat32(a + 1, ovf);
			fpalu_pkg::OP_DEC: r = sat32(a - 1, ovf);
			fpalu_pkg::OP_RND: r = round_shift(a);
			fpalu_pkg::OP_I2F: r = sat32(b * (64'sd1 <<< FRAC), ovf);
			default: r = 0;
		endcase
		res.value = r[31:0];
		res.less = a < b;
		res.equal = a == b;
		res.ovf = ovf;
		res.dbz = dbz;
		return res;
	endfunction

	// directed rows; has_exp marks rows whose result is typed in
	typedef struct {
		logic [KIND_W-1:0]         k;
		logic signed [IO_W-1:0]    a;
		logic signed [IO_W-1:0]    b;
		bit                        has_exp;
		fpalu_tb_pkg::alu_result_t exp;
	} row_t;

	localparam logic signed [IO_W-1:0] MAXV = 32'sh7fffffff;
	localparam logic signed [IO_W-1:0] MINV = 32'sh80000000;

	row_t rows[$];

	task automatic add_row(logic [KIND_W-1:0] k, logic signed [IO_W-1:0] a,
			logic signed [IO_W-1:0] b);
		row_t r;
		r.k = k;
		r.a = a;
		r.b = b;
		r.has_exp = 1'b0;
		rows.push_back(r);
	endtask

	task automatic add_known(logic [KIND_W-1:0] k, logic signed [IO_W-1:0] a,
			logic signed [IO_W-1:0] b, logic signed [IO_W-1:0] v, logic l, logic e,
			logic o, logic d);
		row_t r;
		r.k = k;
		r.a = a;
		r.b = b;
		r.has_exp = 1'b1;
		r.exp.value = v;
		r.exp.less = l;
		r.exp.equal = e;
		r.exp.ovf = o;
		r.exp.dbz = d;
		rows.push_back(r);
	endtask

	task automatic send_beat(logic [KIND_W-1:0] k, logic signed [IO_W-1:0] a,
			logic signed [IO_W-1:0] b, bit has_exp, fpalu_tb_pkg::alu_result_t exp);
		while (!calm && $urandom_range(99) < 13) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= k;
		in_ch.operand_a <= a;
		in_ch.operand_b <= b;
		pending_results.push_back(has_exp ? exp : alu_predict(k, a, b));
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	function automatic logic signed [IO_W-1:0] rand_operand();
		case ($urandom_range(7))
			0: return MAXV;
			1: return MINV;
			2: return $signed(IO_W'($urandom_range(2047))) - 1024;
			3: return $signed(IO_W'($urandom_range(65535))) - 32768;
			4: return 32'sd0;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		fpalu_tb_pkg::alu_result_t none;
		logic [KIND_W-1:0] k;
		none = '{default: 0};
		in_ch.valid = 1'b0;
		in_ch.kind = '0;
		in_ch.operand_a = '0;
		in_ch.operand_b = '0;
		out_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_known(fpalu_pkg::OP_ADD, MAXV, 32'sd1, MAXV, 1'b0, 1'b0, 1'b1, 1'b0);
		add_known(fpalu_pkg::OP_SUB, MINV, 32'sd1, MINV, 1'b1, 1'b0, 1'b1, 1'b0);
		add_known(fpalu_pkg::OP_DIV, 32'sd256, 32'sd0, 32'sd0, 1'b0, 1'b0, 1'b0, 1'b1);
		add_known(fpalu_pkg::OP_INC, MAXV, MAXV, MAXV, 1'b0, 1'b1, 1'b1, 1'b0);
		add_known(fpalu_pkg::OP_DEC, MINV, MINV, MINV, 1'b0, 1'b1, 1'b1, 1'b0);
		add_known(fpalu_pkg::OP_MIN, MINV, MAXV, MINV, 1'b1, 1'b0, 1'b0, 1'b0);
		add_known(fpalu_pkg::OP_MAX, MINV, MAXV, MAXV, 1'b1, 1'b0, 1'b0, 1'b0);
		add_known(4'd15, 32'sd5, 32'sd5, 32'sd0, 1'b0, 1'b1, 1'b0, 1'b0);
		add_known(4'd10, MAXV, MINV, 32'sd0, 1'b0, 1'b0, 1'b0, 1'b0);
		add_row(fpalu_pkg::OP_MUL, MAXV, MAXV);
		add_row(fpalu_pkg::OP_MUL, MINV, MINV);
		add_row(fpalu_pkg::OP_MUL, MINV, MAXV);
		add_row(fpalu_pkg::OP_MUL, 32'sd384, -32'sd128);
		add_row(fpalu_pkg::OP_MUL, 32'sd1, 32'sd128);
		add_row(fpalu_pkg::OP_DIV, MINV, -32'sd1);
		add_row(fpalu_pkg::OP_DIV, MAXV, MINV);
		add_row(fpalu_pkg::OP_DIV, 32'sd1, 32'sd2);
		add_row(fpalu_pkg::OP_DIV, -32'sd3, 32'sd2);
		add_row(fpalu_pkg::OP_RND, 32'sd384, 32'sd0);
		add_row(fpalu_pkg::OP_RND, -32'sd384, 32'sd0);
		add_row(fpalu_pkg::OP_RND, MINV, 32'sd0);
		add_row(fpalu_pkg::OP_RND, MAXV, 32'sd0);
		add_row(fpalu_pkg::OP_I2F, 32'sd0, MAXV);
		add_row(fpalu_pkg::OP_I2F, 32'sd0, MINV);
		add_row(fpalu_pkg::OP_I2F, 32'sd0, -32'sd7);
		foreach (rows[i]) send_beat(rows[i].k, rows[i].a, rows[i].b, rows[i].has_exp, rows[i].exp);

		for (int n = 0; n < N_RANDOM; n++) begin
			calm = (n >= 200 && n < 300);
			if (n == 350) begin
				// drain the pipe before going on
				in_ch.valid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
			k = ($urandom_range(19) == 0) ? KIND_W'($urandom_range(15, 10))
				: KIND_W'($urandom_range(9));
			send_beat(k, rand_operand(), ($urandom_range(9) == 0) ? rand_operand()
				: $urandom, 1'b0, none);
		end
		in_ch.valid <= 1'b0;
		calm = 1'b0;
		stim_done = 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) out_ch.ready <= calm || ($urandom_range(99) >= 13);
	end

	always @(posedge clk) begin
		fpalu_tb_pkg::alu_result_t exp;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat value=%0d", out_ch.result_value);
				errors++;
			end else begin
				exp = pending_results.pop_front();
				if (out_ch.result_value !== exp.value) begin
					$error("result_value expected %0d got %0d", exp.value, out_ch.result_value);
					errors++;
				end
				if (out_ch.a_less !== exp.less) begin
					$error("a_less expected %0b got %0b", exp.less, out_ch.a_less);
					errors++;
				end
				if (out_ch.a_equal !== exp.equal) begin
					$error("a_equal expected %0b got %0b", exp.equal, out_ch.a_equal);
					errors++;
				end
				if (out_ch.overflowed !== exp.ovf) begin
					$error("overflowed expected %0b got %0b", exp.ovf, out_ch.overflowed);
					errors++;
				end
				if (out_ch.divide_by_zero !== exp.dbz) begin
					$error("divide_by_zero expected %0b got %0b", exp.dbz,
						out_ch.divide_by_zero);
					errors++;
				end
			end
		end
	end

	// watchdog on beats in either direction
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2 * WORD + FRAC + 20) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
